// ----- sv/wrpk_pkg.sv -----
// wrpk_pkg: shared types, codes and widths of the weighted random entry picker
package wrpk_pkg;

   // field widths fixed by the request and response formats
   localparam int unsigned ID_W      = 31;
   localparam int unsigned WT_W      = 16;
   localparam int unsigned SLOT_W    = 6;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned WT_MAX    = 65535;
   localparam int unsigned DEF_DEPTH = 64;

   // request modes
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_PICK   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_ZERO  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_REMOVE = 2'd1,
      ST_WALK   = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ID_W-1:0]   entry_id;
      logic [WT_W-1:0]   entry_weight;
      logic [SLOT_W-1:0] slot;
      logic [FRAC_W-1:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] result_slot;
      logic [ID_W-1:0]   result_id;
   } rsp_type;

   // write enables from the sequencer to the entry table
   typedef struct packed {
      logic id_we;
      logic wt_we;
   } tbl_wr_type;

endpackage

// ----- sv/wrpk_table.sv -----
// wrpk_table: entry id and weight memories, one write and one registered read each
module wrpk_table #(
   parameter int unsigned DEPTH = wrpk_pkg::DEF_DEPTH,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  wrpk_pkg::tbl_wr_type    wr,
   input  logic [AW-1:0]           wr_addr,
   input  logic [wrpk_pkg::ID_W-1:0] wr_id,
   input  logic [wrpk_pkg::WT_W-1:0] wr_wt,
   input  logic [AW-1:0]           rd_addr,
   output logic [wrpk_pkg::ID_W-1:0] rd_id,
   output logic [wrpk_pkg::WT_W-1:0] rd_wt
);
   import wrpk_pkg::*;

   logic [ID_W-1:0] id_mem [DEPTH];
   logic [WT_W-1:0] wt_mem [DEPTH];
   logic [ID_W-1:0] rd_id_ff;
   logic [WT_W-1:0] rd_wt_ff;

   // id memory
   always_ff @(posedge clock) begin
      if (wr.id_we) begin
         id_mem[wr_addr] <= wr_id;
      end
      rd_id_ff <= id_mem[rd_addr];
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (wr.wt_we) begin
         wt_mem[wr_addr] <= wr_wt;
      end
      rd_wt_ff <= wt_mem[rd_addr];
   end

   assign rd_id = rd_id_ff;
   assign rd_wt = rd_wt_ff;

endmodule

// ----- sv/weighted_random_entry_picker.sv -----
// weighted_random_entry_picker: roulette-wheel table with add, remove and weighted pick
//
//   channel   | ports                      | handshake
//   ----------+----------------------------+------------------------------------
//   request   | start, busy, req_item      | taken when start high and busy low
//   response  | rsp_strobe, rsp_item       | one cycle, marked by rsp_strobe
//
// add, no-op and every rejected request finish in the cycle they are accepted;
// remove does a weight memory read, then write back and total update in
// ST_REMOVE; a pick walks from slot 0 up to the slot it lands on, reading
// one weight per cycle from the weight memory port.
// the response appears in the cycle after the request finishes; busy is low then.
// reset clears the entry count, weight total and sequencer; no clearing pass.
// the receiver cannot stall, so nothing holds the response back.
module weighted_random_entry_picker #(
   parameter int unsigned TABLE_DEPTH = wrpk_pkg::DEF_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  wrpk_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output wrpk_pkg::rsp_type rsp_item
);
   import wrpk_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned TW = $clog2(TABLE_DEPTH * WT_MAX + 1);
   localparam int unsigned PW = FRAC_W + TW;
   localparam int unsigned XW = (CW > SLOT_W) ? CW : SLOT_W;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [TW-1:0]    total_ff, total_in;
   logic [TW-1:0]    target_ff, target_in;
   logic [TW-1:0]    cum_ff, cum_in;
   logic [AW-1:0]    cur_idx_ff, cur_idx_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   tbl_wr_type       tbl_wr;
   logic [AW-1:0]    wr_addr;
   logic [WT_W-1:0]  wr_wt;
   logic [AW-1:0]    rd_addr;
   logic [ID_W-1:0]  rd_id;
   logic [WT_W-1:0]  rd_wt;

   logic             accept;
   logic             in_range;
   logic [AW-1:0]    slot_addr;
   logic [PW-1:0]    product;
   logic [TW-1:0]    target_c;
   logic [TW-1:0]    cum_sum;
   logic [CW-1:0]    idx_next;
   logic             at_end;

   wrpk_table #(.DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .wr_addr (wr_addr),
      .wr_id   (req_item.entry_id),
      .wr_wt   (wr_wt),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_wt   (rd_wt)
   );

   // handshake and datapath helpers
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign in_range  = XW'(req_item.slot) < XW'(count_ff);
   assign slot_addr = AW'(req_item.slot);
   assign product   = PW'(req_item.random_fraction) * PW'(total_ff);
   assign target_c  = product[PW-1:FRAC_W];
   assign cum_sum   = cum_ff + TW'(rd_wt);
   assign idx_next  = CW'(cur_idx_ff) + CW'(1);
   assign at_end    = (idx_next == count_ff);

   // sequencer: next state, table access and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      cum_in        = cum_ff;
      cur_idx_in    = cur_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      tbl_wr        = '0;
      wr_addr       = AW'(count_ff);
      wr_wt         = req_item.entry_weight;
      rd_addr       = cur_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.mode)
                  MODE_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        tbl_wr.id_we       = 1'b1;
                        tbl_wr.wt_we       = 1'b1;
                        count_in           = count_ff + CW'(1);
                        total_in           = total_ff + TW'(req_item.entry_weight);
                        rsp_in.status      = STAT_OK;
                        rsp_in.result_slot = SLOT_W'(count_ff);
                     end
                  end
                  MODE_REMOVE: begin
                     if (!in_range) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end else begin
                        rd_addr    = slot_addr;
                        cur_idx_in = slot_addr;
                        state_in   = ST_REMOVE;
                     end
                  end
                  MODE_PICK: begin
                     if (total_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_ZERO;
                     end else begin
                        rd_addr    = '0;
                        cur_idx_in = '0;
                        cum_in     = '0;
                        target_in  = target_c;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = STAT_OK;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            // weight read last cycle: take it off the total and clear it
            tbl_wr.wt_we       = 1'b1;
            wr_addr            = cur_idx_ff;
            wr_wt              = '0;
            total_in           = total_ff - TW'(rd_wt);
            rsp_strobe_in      = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.result_slot = SLOT_W'(cur_idx_ff);
            state_in           = ST_IDLE;
         end
         ST_WALK: begin
            // one cumulative step per cycle, next address issued alongside
            if (cum_sum > target_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = STAT_OK;
               rsp_in.result_slot = SLOT_W'(cur_idx_ff);
               rsp_in.result_id   = rd_id;
               state_in           = ST_IDLE;
            end else if (at_end) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STAT_ZERO;
               state_in      = ST_IDLE;
            end else begin
               cum_in     = cum_sum;
               cur_idx_in = AW'(idx_next);
               rd_addr    = AW'(idx_next);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      cum_ff     <= cum_in;
      cur_idx_ff <= cur_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // entry count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // the walk only visits filled slots
   a_walk_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (CW'(cur_idx_ff) < count_ff))
      else $error("walk index past entry count");

   // the running sum has not yet passed the target while walking
   a_walk_cum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cum_ff <= target_ff))
      else $error("cumulative weight passed target without a hit");

   // a response always comes with the sequencer back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   // add answers with a response in the cycle after it is accepted
   a_add_one: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.mode == MODE_ADD)) |=> rsp_strobe)
      else $error("add request without response");

endmodule
